/* design/mpts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpts_pkg
// Shared types and constants of the mutex priority task scheduler.
// ----------------------------------------------------------------------------
package mpts_pkg;

    localparam int MAX_GOALS      = 8;
    localparam int MUTEX_WIDTH    = 8;
    localparam int PRIORITY_WIDTH = 4;

    localparam int GOAL_IDX_W     = $clog2(MAX_GOALS);
    localparam int COUNT_W        = 4;
    localparam int PHASE_W        = 4;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 64;

    localparam logic [PHASE_W-1:0] DEFAULT_EVAL_PERIOD = PHASE_W'(3);

    typedef logic [MAX_GOALS-1:0] goal_mask_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GOAL_COUNT    = 3'd0,
        REG_GOAL_PRIO     = 3'd1,
        REG_MUTEX_MASKS   = 3'd2,
        REG_INTERRUPTIBLE = 3'd3,
        REG_EVAL_PERIOD   = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        ACT_TICK     = 1'b0,
        ACT_STOP_ALL = 1'b1
    } action_t;

    typedef struct packed {
        logic [COUNT_W-1:0]                   goal_count;
        logic [MAX_GOALS*PRIORITY_WIDTH-1:0]  priorities;
        logic [MAX_GOALS*MUTEX_WIDTH-1:0]     mutex_masks;
        goal_mask_t                           interruptible;
        logic [PHASE_W-1:0]                   eval_period;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic step;
        logic publish;
    } dp_cmd_t;

    typedef struct packed {
        logic skip;
        logic last;
    } dp_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_VISIT,
        ST_HOLD
    } ctrl_state_t;

endpackage

/* design/mpts_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpts_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module mpts_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [mpts_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mpts_pkg::CFG_DATA_W-1:0]  cfg_data,
    output mpts_pkg::cfg_t                   cfg
);
    import mpts_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_GOAL_COUNT:    cfg_next.goal_count    = cfg_data[COUNT_W-1:0];
                REG_GOAL_PRIO:     cfg_next.priorities    =
                                       cfg_data[MAX_GOALS*PRIORITY_WIDTH-1:0];
                REG_MUTEX_MASKS:   cfg_next.mutex_masks   =
                                       cfg_data[MAX_GOALS*MUTEX_WIDTH-1:0];
                REG_INTERRUPTIBLE: cfg_next.interruptible = cfg_data[MAX_GOALS-1:0];
                REG_EVAL_PERIOD:   cfg_next.eval_period   = cfg_data[PHASE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.goal_count    <= '0;
            cfg_reg.priorities    <= '0;
            cfg_reg.mutex_masks   <= '0;
            cfg_reg.interruptible <= '0;
            cfg_reg.eval_period   <= DEFAULT_EVAL_PERIOD;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/mpts_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpts_datapath
// Running set, tick phase and per-task visit logic with a parallel
// conflict check against all other running tasks; holds the result word.
// ----------------------------------------------------------------------------
module mpts_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mpts_pkg::cfg_t        cfg,
    input  mpts_pkg::dp_cmd_t     cmd,
    output mpts_pkg::dp_status_t  status,
    input  logic                  in_action,
    input  mpts_pkg::goal_mask_t  in_want,
    input  mpts_pkg::goal_mask_t  in_keep,
    output mpts_pkg::goal_mask_t  out_running,
    output mpts_pkg::goal_mask_t  out_started,
    output mpts_pkg::goal_mask_t  out_stopped,
    output logic                  out_full
);
    import mpts_pkg::*;

    goal_mask_t              run_reg, run_next;
    goal_mask_t              started_reg, started_next;
    goal_mask_t              stopped_reg, stopped_next;
    goal_mask_t              want_reg, want_next;
    goal_mask_t              keep_reg, keep_next;
    logic                    full_reg, full_next;
    logic                    action_reg, action_next;
    logic [PHASE_W-1:0]      phase_reg, phase_next;
    logic [GOAL_IDX_W-1:0]   idx_reg, idx_next;

    goal_mask_t              res_running_reg, res_started_reg, res_stopped_reg;
    logic                    res_full_reg;

    logic [COUNT_W-1:0]      goal_n;
    goal_mask_t              active;
    logic [PHASE_W-1:0]      period;
    logic [PHASE_W-1:0]      phase_inc;

    logic [PRIORITY_WIDTH-1:0] prio   [MAX_GOALS];
    logic [MUTEX_WIDTH-1:0]    mutex  [MAX_GOALS];
    logic [PRIORITY_WIDTH-1:0] cur_prio;
    logic [MUTEX_WIDTH-1:0]    cur_mutex;
    goal_mask_t                cur_bit;
    goal_mask_t                conflict;
    goal_mask_t                blockers;
    logic                      blocked;

    always_comb begin
        goal_n = (cfg.goal_count > COUNT_W'(MAX_GOALS)) ? COUNT_W'(MAX_GOALS)
                                                         : cfg.goal_count;
        for (int i = 0; i < MAX_GOALS; i++) begin
            active[i] = (COUNT_W'(i) < goal_n);
            prio[i]   = cfg.priorities[i*PRIORITY_WIDTH +: PRIORITY_WIDTH];
            mutex[i]  = cfg.mutex_masks[i*MUTEX_WIDTH +: MUTEX_WIDTH];
        end
        period    = (cfg.eval_period == '0) ? PHASE_W'(1) : cfg.eval_period;
        phase_inc = phase_reg + PHASE_W'(1);
    end

    // conflict check of the visited task against every other running task
    always_comb begin
        cur_prio  = prio[idx_reg];
        cur_mutex = mutex[idx_reg];
        cur_bit   = '0;
        cur_bit[idx_reg] = 1'b1;
        for (int j = 0; j < MAX_GOALS; j++) begin
            conflict[j] = run_reg[j] && !cur_bit[j] && ((mutex[j] & cur_mutex) != '0);
            blockers[j] = conflict[j] && !((cur_prio < prio[j]) && cfg.interruptible[j]);
        end
        blocked = (blockers != '0);
    end

    always_comb begin
        run_next     = run_reg;
        started_next = started_reg;
        stopped_next = stopped_reg;
        want_next    = want_reg;
        keep_next    = keep_reg;
        full_next    = full_reg;
        action_next  = action_reg;
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        if (cmd.load) begin
            want_next    = in_want & active;
            keep_next    = in_keep & active;
            action_next  = in_action;
            started_next = '0;
            idx_next     = '0;
            if (in_action == ACT_STOP_ALL) begin
                stopped_next = run_reg & active;
                run_next     = '0;
                full_next    = 1'b0;
            end else begin
                stopped_next = '0;
                run_next     = run_reg & active;
                if (phase_inc >= period) begin
                    full_next  = 1'b1;
                    phase_next = '0;
                end else begin
                    full_next  = 1'b0;
                    phase_next = phase_inc;
                end
            end
        end else if (cmd.step) begin
            idx_next = idx_reg + GOAL_IDX_W'(1);
            if ((run_reg & cur_bit) != '0) begin
                if (((keep_reg & cur_bit) == '0) || blocked) begin
                    run_next     = run_reg & ~cur_bit;
                    stopped_next = stopped_reg | cur_bit;
                end
            end else if (full_reg && !blocked && ((want_reg & cur_bit) != '0)) begin
                // what conflicts and does not block is preempted
                run_next     = (run_reg & ~conflict) | cur_bit;
                stopped_next = stopped_reg | conflict;
                started_next = started_reg | cur_bit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg   <= '0;
            phase_reg <= '0;
        end else begin
            run_reg   <= run_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        started_reg <= started_next;
        stopped_reg <= stopped_next;
        want_reg    <= want_next;
        keep_reg    <= keep_next;
        full_reg    <= full_next;
        action_reg  <= action_next;
        idx_reg     <= idx_next;
        if (cmd.publish) begin
            res_running_reg <= run_reg;
            res_started_reg <= started_reg;
            res_stopped_reg <= stopped_reg;
            res_full_reg    <= full_reg;
        end
    end

    assign status.skip = (action_reg == ACT_STOP_ALL) || (goal_n == '0);
    assign status.last = (({1'b0, idx_reg} + COUNT_W'(1)) == goal_n);

    assign out_running = res_running_reg;
    assign out_started = res_started_reg;
    assign out_stopped = res_stopped_reg;
    assign out_full    = res_full_reg;

endmodule

/* design/mpts_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpts_ctrl
// Sequencer: takes a word, walks the tasks one per cycle (not for stop-all or
// zero tasks), then hands the result to the output register when it is free.
// ----------------------------------------------------------------------------
module mpts_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output mpts_pkg::dp_cmd_t     cmd,
    input  mpts_pkg::dp_status_t  status
);
    import mpts_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        out_free     = !m_valid_reg || m_tready;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd          = '0;
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_VISIT;
                end
            end
            ST_VISIT: begin
                if (status.skip) begin
                    state_next = ST_HOLD;
                end else begin
                    cmd.step = 1'b1;
                    if (status.last) begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    cmd.publish  = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = m_valid_reg;

endmodule

/* design/mutex_priority_task_scheduler_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mutex_priority_task_scheduler_top
// One item in flight: the next word is taken in the cycle after the result
// is handed to the output register. The task walk visits one task per cycle,
// skipped for stop-all or zero tasks; a stalled output holds the finished walk
// until the output register is free.
// Synchronous active-low reset: all tasks idle, tick phase zero, eval
// period 3, other configuration registers zero; the remaining datapath
// registers are not reset.
// ----------------------------------------------------------------------------
module mutex_priority_task_scheduler_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [mpts_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mpts_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,  // want_start, keep_running
    input  logic [0:0]                       s_tuser,  // action
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [23:0]                      m_tdata,  // running, started, stopped
    output logic [0:0]                       m_tuser   // full_evaluation
);
    import mpts_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;
    goal_mask_t out_running, out_started, out_stopped;
    logic       out_full;

    mpts_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mpts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    mpts_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .cmd         (cmd),
        .status      (status),
        .in_action   (s_tuser[0]),
        .in_want     (s_tdata[7:0]),
        .in_keep     (s_tdata[15:8]),
        .out_running (out_running),
        .out_started (out_started),
        .out_stopped (out_stopped),
        .out_full    (out_full)
    );

    assign m_tdata = {out_stopped, out_started, out_running};
    assign m_tuser = out_full;

endmodule
